/* src/hsfc_pkg.sv */
package hsfc_pkg;

	typedef enum logic {
		CMD_S2H = 1'b0,
		CMD_H2S = 1'b1
	} cmd_t;

	typedef enum logic [4:0] {
		CLS_ZERO   = 5'b00001,
		CLS_DENORM = 5'b00010,
		CLS_NORM   = 5'b00100,
		CLS_INF    = 5'b01000,
		CLS_NAN    = 5'b10000
	} cls_t;

	localparam logic [7:0] BIAS_DIFF      = 8'd112;
	localparam logic [7:0] S2H_EXP_FLUSH  = 8'd102;
	localparam logic [7:0] S2H_EXP_DN_OFS = 8'd113;
	localparam logic [7:0] S2H_EXP_OVF    = 8'd142;
	localparam logic [7:0] SGL_EXP_ONES   = 8'hff;
	localparam logic [4:0] HLF_EXP_ONES   = 5'h1f;

	typedef struct packed {
		cmd_t        cmd;
		logic        sign;
		cls_t        cls;
		logic [7:0]  exp;
		logic [22:0] man;
		logic [3:0]  shamt;
	} s1_t;

	typedef struct packed {
		cmd_t       cmd;
		logic       sign;
		cls_t       cls;
		logic [7:0] exp;
		logic [9:0] man;
	} s2_t;

endpackage

/* src/hsfc_if.sv */
interface hsfc_req_if;
	logic              valid;
	logic              ready;
	hsfc_pkg::cmd_t    command;
	logic [31:0]       operand_bits;

	modport source (output valid, output command, output operand_bits, input ready);
	modport sink   (input valid, input command, input operand_bits, output ready);
endinterface

interface hsfc_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;

	modport source (output valid, output result_bits, input ready);
	modport sink   (input valid, input result_bits, output ready);
endinterface

/* src/hsfc_decode.sv */
module hsfc_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            in_valid,
	input  hsfc_pkg::cmd_t  command,
	input  logic [31:0]     operand_bits,
	output logic            valid_s1,
	output hsfc_pkg::s1_t   data_s1
);

	hsfc_pkg::s1_t nxt;

	// leading zeros of a half mantissa, only meaningful when nonzero
	function automatic logic [3:0] lzc10(input logic [9:0] m);
		logic [3:0] p;
		p = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				p = 4'(9 - i);
			end
		end
		return p;
	endfunction

	always_comb begin
		nxt.cmd   = command;
		nxt.sign  = 1'b0;
		nxt.cls   = hsfc_pkg::CLS_ZERO;
		nxt.exp   = 8'd0;
		nxt.man   = 23'd0;
		nxt.shamt = 4'd0;
		if (command == hsfc_pkg::CMD_S2H) begin
			nxt.sign  = operand_bits[31];
			nxt.exp   = operand_bits[30:23];
			nxt.man   = operand_bits[22:0];
			nxt.shamt = 4'(hsfc_pkg::S2H_EXP_DN_OFS - operand_bits[30:23]);
			priority if (operand_bits[30:23] < hsfc_pkg::S2H_EXP_FLUSH) begin
				// flushed values lose their sign
				nxt.cls  = hsfc_pkg::CLS_ZERO;
				nxt.sign = 1'b0;
			end else if (operand_bits[30:23] <= hsfc_pkg::BIAS_DIFF) begin
				nxt.cls = hsfc_pkg::CLS_DENORM;
			end else if (operand_bits[30:23] == hsfc_pkg::SGL_EXP_ONES) begin
				nxt.cls = (operand_bits[22:0] == 23'd0) ? hsfc_pkg::CLS_INF
				                                        : hsfc_pkg::CLS_NAN;
			end else if (operand_bits[30:23] > hsfc_pkg::S2H_EXP_OVF) begin
				nxt.cls = hsfc_pkg::CLS_INF;
			end else begin
				nxt.cls = hsfc_pkg::CLS_NORM;
			end
		end else begin
			nxt.sign  = operand_bits[15];
			nxt.exp   = {3'd0, operand_bits[14:10]};
			nxt.man   = {operand_bits[9:0], 13'd0};
			nxt.shamt = lzc10(operand_bits[9:0]);
			priority if (operand_bits[14:10] == 5'd0) begin
				nxt.cls = (operand_bits[9:0] == 10'd0) ? hsfc_pkg::CLS_ZERO
				                                       : hsfc_pkg::CLS_DENORM;
			end else if (operand_bits[14:10] == hsfc_pkg::HLF_EXP_ONES) begin
				nxt.cls = (operand_bits[9:0] == 10'd0) ? hsfc_pkg::CLS_INF
				                                       : hsfc_pkg::CLS_NAN;
			end else begin
				nxt.cls = hsfc_pkg::CLS_NORM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

/* src/hsfc_shift.sv */
module hsfc_shift (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           valid_s1,
	input  hsfc_pkg::s1_t  data_s1,
	output logic           valid_s2,
	output hsfc_pkg::s2_t  data_s2
);

	hsfc_pkg::s2_t nxt;
	logic [23:0]   dn_wide;
	logic [9:0]    h_norm;

	// single denormal: hidden one in, shift right by 1..11
	assign dn_wide = {1'b1, data_s1.man} >> data_s1.shamt;
	// half denormal: leading one moves up to bit 9
	assign h_norm  = data_s1.man[22:13] << data_s1.shamt;

	always_comb begin
		nxt.cmd  = data_s1.cmd;
		nxt.sign = data_s1.sign;
		nxt.cls  = data_s1.cls;
		nxt.exp  = 8'd0;
		nxt.man  = data_s1.man[22:13];
		if (data_s1.cmd == hsfc_pkg::CMD_S2H) begin
			unique case (data_s1.cls)
				hsfc_pkg::CLS_NORM:   nxt.exp = data_s1.exp - hsfc_pkg::BIAS_DIFF;
				hsfc_pkg::CLS_DENORM: nxt.man = dn_wide[22:13];
				default: ;
			endcase
		end else begin
			unique case (data_s1.cls)
				hsfc_pkg::CLS_NORM: nxt.exp = data_s1.exp + hsfc_pkg::BIAS_DIFF;
				hsfc_pkg::CLS_DENORM: begin
					nxt.exp = hsfc_pkg::BIAS_DIFF - {4'd0, data_s1.shamt};
					nxt.man = {h_norm[8:0], 1'b0};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule

/* src/hsfc_pack.sv */
module hsfc_pack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           valid_s2,
	input  hsfc_pkg::s2_t  data_s2,
	output logic           valid_s3,
	output logic [31:0]    result_s3
);

	logic [31:0]   nxt;
	logic [9:0]    nan_man;
	hsfc_pkg::s2_t info_s3;

	// a NaN must keep a nonzero mantissa
	assign nan_man = data_s2.man | {9'd0, (data_s2.man == 10'd0)};

	always_comb begin
		if (data_s2.cmd == hsfc_pkg::CMD_S2H) begin
			unique case (data_s2.cls)
				hsfc_pkg::CLS_ZERO:
					nxt = {16'd0, data_s2.sign, 15'd0};
				hsfc_pkg::CLS_DENORM:
					nxt = {16'd0, data_s2.sign, 5'd0, data_s2.man};
				hsfc_pkg::CLS_NORM:
					nxt = {16'd0, data_s2.sign, data_s2.exp[4:0], data_s2.man};
				hsfc_pkg::CLS_INF:
					nxt = {16'd0, data_s2.sign, hsfc_pkg::HLF_EXP_ONES, 10'd0};
				hsfc_pkg::CLS_NAN:
					nxt = {16'd0, data_s2.sign, hsfc_pkg::HLF_EXP_ONES, nan_man};
				default:
					nxt = 32'd0;
			endcase
		end else begin
			unique case (data_s2.cls)
				hsfc_pkg::CLS_ZERO:
					nxt = {data_s2.sign, 31'd0};
				hsfc_pkg::CLS_DENORM,
				hsfc_pkg::CLS_NORM:
					nxt = {data_s2.sign, data_s2.exp, data_s2.man, 13'd0};
				hsfc_pkg::CLS_INF:
					nxt = {data_s2.sign, hsfc_pkg::SGL_EXP_ONES, 23'd0};
				hsfc_pkg::CLS_NAN:
					nxt = {data_s2.sign, hsfc_pkg::SGL_EXP_ONES, nan_man, 13'd0};
				default:
					nxt = 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			result_s3 <= nxt;
			info_s3   <= data_s2;
		end
	end

`ifndef NO_ASSERTIONS
	a_half_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && info_s3.cmd == hsfc_pkg::CMD_S2H |-> result_s3[31:16] == 16'd0)
		else $error("half result has nonzero upper bits");

	a_nan_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && info_s3.cls == hsfc_pkg::CLS_NAN && info_s3.cmd == hsfc_pkg::CMD_S2H
		|-> result_s3[14:10] == hsfc_pkg::HLF_EXP_ONES && result_s3[9:0] != 10'd0)
		else $error("NaN input did not give a half NaN");
`endif

endmodule

/* src/half_single_float_converter_unit.sv */
// Half/single float converter.
// req channel: command (CMD_S2H or CMD_H2S) and operand_bits; a half operand sits in
// bits 15..0 and bits 31..16 are ignored. rsp channel: result_bits; a half result
// sits in bits 15..0 with bits 31..16 zero.
// Single to half truncates the mantissa, flushes tiny values to +0 and saturates
// overflow to a signed infinity. Half to single is exact.
// Three register stages: classify with leading-zero count, mantissa shift with
// exponent rebias, result packing. An accepted request is registered in each stage
// in turn and is then offered on rsp. Throughput is one request per cycle while rsp
// is not stalled; each stage advances when the stage after it is empty or moving,
// so req.ready is low only when all three stages hold an item and rsp is stalled.
// A stall holds stage 3 and each full stage in an unbroken run behind it in place.
// Reset clears the stage valid bits; the block is stateless otherwise.
module half_single_float_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	hsfc_req_if.sink   req,
	hsfc_rsp_if.source rsp
);

	logic          adv1, adv2, adv3;
	logic          valid_s1, valid_s2, valid_s3;
	hsfc_pkg::s1_t data_s1;
	hsfc_pkg::s2_t data_s2;
	logic [31:0]   result_s3;

	assign adv3 = !valid_s3 || rsp.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign req.ready       = adv1;
	assign rsp.valid       = valid_s3;
	assign rsp.result_bits = result_s3;

	hsfc_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (adv1),
		.in_valid     (req.valid),
		.command      (req.command),
		.operand_bits (req.operand_bits),
		.valid_s1     (valid_s1),
		.data_s1      (data_s1)
	);

	hsfc_shift u_shift (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	hsfc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (adv3),
		.valid_s2  (valid_s2),
		.data_s2   (data_s2),
		.valid_s3  (valid_s3),
		.result_s3 (result_s3)
	);

`ifndef NO_ASSERTIONS
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_s2 && valid_s3)
		else $error("request stalled with a free pipeline stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request missing from first stage");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && valid_s3 && !rsp.ready |=> valid_s2 && valid_s3)
		else $error("item dropped during output stall");
`endif

endmodule
